>>> src/dvru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared codes, widths and the control token of the route table cell chain.
// ----------------------------------------------------------------------------
package dvru_pkg;

    localparam int KIND_W    = 2;
    localparam int OUTCOME_W = 3;
    localparam int METRIC_W  = 5;
    localparam int RIDX_W    = 4;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADV  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_LOADED   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_KEPT     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED  = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_READ     = 3'd5;

    localparam logic [METRIC_W-1:0] METRIC_INF = 5'd16;

    // Control part of the item token that walks down the chain
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              found;    // result captured (match, append or read)
        logic              matched;  // some entry had the advertised destination
        logic              written;  // some matching entry was rewritten
    } tok_ctl_t;

endpackage

>>> src/dvru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru_cell
// One route table entry. Applies the passing item to its entry and hands the
// item, with the running result, to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module dvru_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int ID_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dvru_pkg::tok_ctl_t           ctl_in,
    input  logic [ID_BITS-1:0]           sender_in,
    input  logic [ID_BITS-1:0]           dest_in,
    input  logic [dvru_pkg::METRIC_W-1:0] metric_in,
    input  logic [ID_BITS-1:0]           hop_in,
    input  logic [dvru_pkg::RIDX_W-1:0]  ridx_in,
    input  logic [IDX_W-1:0]             res_idx_in,
    input  logic                         res_valid_in,
    input  logic [ID_BITS-1:0]           res_dest_in,
    input  logic [dvru_pkg::METRIC_W-1:0] res_metric_in,
    input  logic [ID_BITS-1:0]           res_hop_in,
    output dvru_pkg::tok_ctl_t           ctl_out,
    output logic [ID_BITS-1:0]           sender_out,
    output logic [ID_BITS-1:0]           dest_out,
    output logic [dvru_pkg::METRIC_W-1:0] metric_out,
    output logic [ID_BITS-1:0]           hop_out,
    output logic [dvru_pkg::RIDX_W-1:0]  ridx_out,
    output logic [IDX_W-1:0]             res_idx_out,
    output logic                         res_valid_out,
    output logic [ID_BITS-1:0]           res_dest_out,
    output logic [dvru_pkg::METRIC_W-1:0] res_metric_out,
    output logic [ID_BITS-1:0]           res_hop_out
);
    import dvru_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                valid_reg, valid_next;
    logic [ID_BITS-1:0]  dest_reg, dest_next;
    logic [METRIC_W-1:0] metric_reg, metric_next;
    logic [ID_BITS-1:0]  hop_reg, hop_next;

    tok_ctl_t            ctl_reg, ctl_next;
    logic [ID_BITS-1:0]  sender_reg, tdest_reg, thop_reg;
    logic [METRIC_W-1:0] tmetric_reg;
    logic [RIDX_W-1:0]   ridx_reg;
    logic [IDX_W-1:0]    ridx_out_reg, ridx_out_next;
    logic                rvalid_reg, rvalid_next;
    logic [ID_BITS-1:0]  rdest_reg, rdest_next, rhop_reg, rhop_next;
    logic [METRIC_W-1:0] rmetric_reg, rmetric_next;

    logic match;
    logic append;
    logic read_hit;

    assign match    = ctl_in.valid && (ctl_in.kind == KIND_ADV) && valid_reg
                      && (dest_reg == dest_in);
    // valid entries are contiguous, so the first free cell is the append slot
    assign append   = ctl_in.valid && !ctl_in.found && !valid_reg
                      && ((ctl_in.kind == KIND_LOAD)
                          || ((ctl_in.kind == KIND_ADV) && !ctl_in.matched));
    assign read_hit = ctl_in.valid && (ctl_in.kind == KIND_READ)
                      && (CELL_IDX < (1 << RIDX_W))
                      && (ridx_in == RIDX_W'(CELL_IDX));

    always_comb
    begin
        valid_next    = valid_reg;
        dest_next     = dest_reg;
        metric_next   = metric_reg;
        hop_next      = hop_reg;
        ctl_next      = ctl_in;
        ridx_out_next = res_idx_in;
        rvalid_next   = res_valid_in;
        rdest_next    = res_dest_in;
        rmetric_next  = res_metric_in;
        rhop_next     = res_hop_in;

        if (match) begin
            if (hop_reg == sender_in) begin
                metric_next      = metric_in;
                ctl_next.written = 1'b1;
            end else if (metric_reg > metric_in) begin
                metric_next      = metric_in;
                hop_next         = sender_in;
                ctl_next.written = 1'b1;
            end
            if (!ctl_in.matched) begin
                ctl_next.matched = 1'b1;
                ctl_next.found   = 1'b1;
                ridx_out_next    = MY_IDX;
                rvalid_next      = 1'b1;
                rdest_next       = dest_reg;
                rmetric_next     = metric_next;
                rhop_next        = hop_next;
            end
        end

        if (append) begin
            valid_next     = 1'b1;
            dest_next      = dest_in;
            metric_next    = metric_in;
            hop_next       = hop_in;
            ctl_next.found = 1'b1;
            ridx_out_next  = MY_IDX;
            rvalid_next    = 1'b1;
            rdest_next     = dest_in;
            rmetric_next   = metric_in;
            rhop_next      = hop_in;
        end

        if (read_hit) begin
            ctl_next.found = 1'b1;
            rvalid_next    = valid_reg;
            rdest_next     = valid_reg ? dest_reg : '0;
            rmetric_next   = valid_reg ? metric_reg : '0;
            rhop_next      = valid_reg ? hop_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg     <= dest_next;
        metric_reg   <= metric_next;
        hop_reg      <= hop_next;
        sender_reg   <= sender_in;
        tdest_reg    <= dest_in;
        tmetric_reg  <= metric_in;
        thop_reg     <= hop_in;
        ridx_reg     <= ridx_in;
        ridx_out_reg <= ridx_out_next;
        rvalid_reg   <= rvalid_next;
        rdest_reg    <= rdest_next;
        rmetric_reg  <= rmetric_next;
        rhop_reg     <= rhop_next;
    end

    assign ctl_out        = ctl_reg;
    assign sender_out     = sender_reg;
    assign dest_out       = tdest_reg;
    assign metric_out     = tmetric_reg;
    assign hop_out        = thop_reg;
    assign ridx_out       = ridx_reg;
    assign res_idx_out    = ridx_out_reg;
    assign res_valid_out  = rvalid_reg;
    assign res_dest_out   = rdest_reg;
    assign res_metric_out = rmetric_reg;
    assign res_hop_out    = rhop_reg;

endmodule

>>> src/distance_vector_route_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_update
// Distance-vector route table built as a chain of one cell per entry.
// An accepted item walks the whole cell chain; the result and the done strobe
// are registered as it leaves the last cell. A new item is taken only after
// that, since busy stays high until the item leaves the last cell.
// Reset clears all entry valid bits and the chain; results cannot be stalled.
// ----------------------------------------------------------------------------
module distance_vector_route_update #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_BITS       = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dvru_pkg::KIND_W-1:0]    kind,
    input  logic [ID_BITS-1:0]             sender_id,
    input  logic [ID_BITS-1:0]             dest_id,
    input  logic [7:0]                     metric_in,
    input  logic [ID_BITS-1:0]             load_hop,
    input  logic [dvru_pkg::RIDX_W-1:0]    read_index,
    output logic                           done,
    output logic [dvru_pkg::OUTCOME_W-1:0] outcome,
    output logic [3:0]                     entry_index,
    output logic                           entry_valid,
    output logic [ID_BITS-1:0]             entry_dest,
    output logic [dvru_pkg::METRIC_W-1:0]  entry_metric,
    output logic [ID_BITS-1:0]             entry_hop
);
    import dvru_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    tok_ctl_t            ctl    [0:TABLE_ENTRIES];
    logic [ID_BITS-1:0]  snd    [0:TABLE_ENTRIES];
    logic [ID_BITS-1:0]  dst    [0:TABLE_ENTRIES];
    logic [METRIC_W-1:0] met    [0:TABLE_ENTRIES];
    logic [ID_BITS-1:0]  hop    [0:TABLE_ENTRIES];
    logic [RIDX_W-1:0]   ridx   [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]    r_idx  [0:TABLE_ENTRIES];
    logic                r_vld  [0:TABLE_ENTRIES];
    logic [ID_BITS-1:0]  r_dst  [0:TABLE_ENTRIES];
    logic [METRIC_W-1:0] r_met  [0:TABLE_ENTRIES];
    logic [ID_BITS-1:0]  r_hop  [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0] tok_valids;

    logic                accept;
    logic [METRIC_W-1:0] metric_sat;
    logic [METRIC_W-1:0] metric_adv;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;
    logic [3:0]          idx_reg, idx_next;
    logic                evalid_reg, evalid_next;
    logic [ID_BITS-1:0]  edest_reg, edest_next, ehop_reg, ehop_next;
    logic [METRIC_W-1:0] emetric_reg, emetric_next;

    assign accept     = start && !busy_reg;
    assign metric_sat = (metric_in > 8'(METRIC_INF)) ? METRIC_INF : METRIC_W'(metric_in);
    assign metric_adv = (metric_sat == METRIC_INF) ? METRIC_INF
                                                   : metric_sat + METRIC_W'(1);

    // chain head: item enters cell 0 in the cycle it is accepted
    always_comb
    begin
        ctl[0]       = '0;
        ctl[0].valid = accept;
        ctl[0].kind  = kind;
        met[0]       = (kind == KIND_ADV) ? metric_adv : metric_sat;
        hop[0]       = (kind == KIND_ADV) ? sender_id : load_hop;
    end
    assign snd[0]   = sender_id;
    assign dst[0]   = dest_id;
    assign ridx[0]  = read_index;
    assign r_idx[0] = '0;
    assign r_vld[0] = 1'b0;
    assign r_dst[0] = '0;
    assign r_met[0] = '0;
    assign r_hop[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            dvru_cell #(
                .CELL_IDX (g),
                .IDX_W    (IDX_W),
                .ID_BITS  (ID_BITS)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl_in         (ctl[g]),
                .sender_in      (snd[g]),
                .dest_in        (dst[g]),
                .metric_in      (met[g]),
                .hop_in         (hop[g]),
                .ridx_in        (ridx[g]),
                .res_idx_in     (r_idx[g]),
                .res_valid_in   (r_vld[g]),
                .res_dest_in    (r_dst[g]),
                .res_metric_in  (r_met[g]),
                .res_hop_in     (r_hop[g]),
                .ctl_out        (ctl[g+1]),
                .sender_out     (snd[g+1]),
                .dest_out       (dst[g+1]),
                .metric_out     (met[g+1]),
                .hop_out        (hop[g+1]),
                .ridx_out       (ridx[g+1]),
                .res_idx_out    (r_idx[g+1]),
                .res_valid_out  (r_vld[g+1]),
                .res_dest_out   (r_dst[g+1]),
                .res_metric_out (r_met[g+1]),
                .res_hop_out    (r_hop[g+1])
            );
        end
        for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
            assign tok_valids[g] = ctl[g].valid;
        end
    endgenerate

    // item leaves the last cell: form the result
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        outcome_next = outcome_reg;
        idx_next     = idx_reg;
        evalid_next  = evalid_reg;
        edest_next   = edest_reg;
        emetric_next = emetric_reg;
        ehop_next    = ehop_reg;

        if (accept)
            busy_next = 1'b1;

        if (ctl[TABLE_ENTRIES].valid) begin
            busy_next    = 1'b0;
            done_next    = ctl[TABLE_ENTRIES].kind inside {KIND_LOAD, KIND_ADV, KIND_READ};
            idx_next     = 4'(r_idx[TABLE_ENTRIES]);
            evalid_next  = r_vld[TABLE_ENTRIES];
            edest_next   = r_dst[TABLE_ENTRIES];
            emetric_next = r_met[TABLE_ENTRIES];
            ehop_next    = r_hop[TABLE_ENTRIES];
            case (ctl[TABLE_ENTRIES].kind)
                KIND_LOAD: outcome_next = OUT_LOADED;
                KIND_ADV:
                begin
                    if (ctl[TABLE_ENTRIES].matched)
                        outcome_next = ctl[TABLE_ENTRIES].written ? OUT_UPDATED : OUT_KEPT;
                    else
                        outcome_next = OUT_INSERTED;
                end
                KIND_READ:
                begin
                    outcome_next = OUT_READ;
                    idx_next     = ridx[TABLE_ENTRIES];
                end
                default: outcome_next = outcome_reg;
            endcase
            // table full: report the dropped route
            if ((ctl[TABLE_ENTRIES].kind == KIND_LOAD || ctl[TABLE_ENTRIES].kind == KIND_ADV)
                && !ctl[TABLE_ENTRIES].found) begin
                outcome_next = OUT_DROPPED;
                idx_next     = '0;
                evalid_next  = 1'b0;
                edest_next   = dst[TABLE_ENTRIES];
                emetric_next = met[TABLE_ENTRIES];
                ehop_next    = hop[TABLE_ENTRIES];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        idx_reg     <= idx_next;
        evalid_reg  <= evalid_next;
        edest_reg   <= edest_next;
        emetric_reg <= emetric_next;
        ehop_reg    <= ehop_next;
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign entry_index  = idx_reg;
    assign entry_valid  = evalid_reg;
    assign entry_dest   = edest_reg;
    assign entry_metric = emetric_reg;
    assign entry_hop    = ehop_reg;

    // only one item in the chain at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valids))
        else $error("more than one item in the cell chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after accept");

    a_exit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl[TABLE_ENTRIES].valid |=> !busy_reg)
        else $error("busy held after item left the chain");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobed while busy");

endmodule
